// ----- hw/rtl/bankers_safety_check_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for bankers_safety_check_top
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_CHECK_TOP_ASSERT_SVH
`define BANKERS_SAFETY_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define BSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsc assertion failed");

// next-cycle implication
`define BSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsc assertion failed");

`endif

// ----- hw/rtl/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants and types of the safety check block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int unsigned MAX_PROCESSES = 16;
  localparam int unsigned NUM_RES       = 3;
  localparam int unsigned RES_W         = 8;
  localparam int unsigned NEED_W        = RES_W + 1;
  localparam int unsigned IDX_W         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned SUM_W         = $clog2(MAX_PROCESSES * 255 + 1);
  localparam int unsigned FREE_W        = (SUM_W + 1 > 13) ? SUM_W + 1 : 13;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_C = 2'd2;

  typedef struct packed {
    logic              fits;
    logic [FREE_W-1:0] free_next;
  } lane_res_t;

  typedef struct packed {
    logic [NUM_RES-1:0][RES_W-1:0]  held;
    logic [NUM_RES-1:0][NEED_W-1:0] need;
  } proc_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]               order;
    logic [NUM_RES-1:0][FREE_W-1:0] free;
  } res_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bsc_lane.sv -----
// ----------------------------------------------------------------------------
// bsc_lane
// One resource lane: need-versus-available compare and release add.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_lane (
  input  logic signed [bsc_pkg::FREE_W-1:0] free_i,
  input  logic        [bsc_pkg::RES_W-1:0]  held_i,
  input  logic        [bsc_pkg::NEED_W-1:0] need_i,
  output bsc_pkg::lane_res_t                res_o
);

  logic signed [bsc_pkg::FREE_W-1:0] need_ext;
  logic signed [bsc_pkg::FREE_W-1:0] held_ext;

  assign need_ext = $signed({{(bsc_pkg::FREE_W - bsc_pkg::NEED_W){need_i[bsc_pkg::NEED_W-1]}},
                             need_i});
  assign held_ext = $signed({{(bsc_pkg::FREE_W - bsc_pkg::RES_W){1'b0}}, held_i});

  assign res_o.fits      = (need_ext <= free_i);
  assign res_o.free_next = free_i + held_ext;

endmodule

`default_nettype wire

// ----- hw/rtl/bankers_safety_check_top.sv -----
// ----------------------------------------------------------------------------
// bankers_safety_check_top
// Banker's algorithm safety check over three resource types.
// ----------------------------------------------------------------------------
// Process items load at one per cycle while busy is low. The item with
// final_process set starts the check: busy then stays high through the
// INIT state, which forms the initial availability, WALK, where the three
// resource lanes test one process per cycle out of the process memory in
// n passes over the n processes loaded, and EMIT, one result per process,
// until the last is out. The results come one per cycle on result_valid_o
// and cannot be stalled; the receiver must take each in the cycle it appears.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_safety_check_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        held_a_i,
  input  logic [7:0]                        held_b_i,
  input  logic [7:0]                        held_c_i,
  input  logic [7:0]                        claim_a_i,
  input  logic [7:0]                        claim_b_i,
  input  logic [7:0]                        claim_c_i,
  input  logic                              final_process_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [7:0]                        cfg_data_i,
  output logic                              result_valid_o,
  output logic [3:0]                        process_index_o,
  output logic [4:0]                        finish_order_o,
  output logic signed [12:0]                free_a_after_o,
  output logic signed [12:0]                free_b_after_o,
  output logic signed [12:0]                free_c_after_o,
  output logic                              system_safe_o,
  output logic                              last_result_o
);

  localparam int unsigned MaxP   = bsc_pkg::MAX_PROCESSES;
  localparam int unsigned NumRes = bsc_pkg::NUM_RES;
  localparam int unsigned ResW   = bsc_pkg::RES_W;
  localparam int unsigned IdxW   = bsc_pkg::IDX_W;
  localparam int unsigned CntW   = bsc_pkg::CNT_W;
  localparam int unsigned SumW   = bsc_pkg::SUM_W;
  localparam int unsigned FreeW  = bsc_pkg::FREE_W;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [IdxW-1:0]              eidx_q;
  logic [IdxW-1:0]              pass_q;
  logic [CntW-1:0]              loaded_q;
  logic [CntW-1:0]              granted_q;
  logic [MaxP-1:0]              fin_q;
  logic [NumRes-1:0][ResW-1:0]  total_q;
  logic [NumRes-1:0][SumW-1:0]  sum_q;
  logic [NumRes-1:0][FreeW-1:0] free_q;

  logic [NumRes-1:0][ResW-1:0]  held_in;
  logic [NumRes-1:0][ResW-1:0]  claim_in;

  bsc_pkg::proc_entry_t         pmem [MaxP];
  bsc_pkg::proc_entry_t         prd_q;
  bsc_pkg::proc_entry_t         pwr;
  bsc_pkg::res_entry_t          rmem [MaxP];
  bsc_pkg::res_entry_t          rrd_q;
  bsc_pkg::res_entry_t          rwr;

  bsc_pkg::lane_res_t           lane_res [NumRes];

  logic                         accept;
  logic                         room;
  logic                         idx_wrap;
  logic                         eidx_end;
  logic                         pass_end;
  logic                         fits_all;
  logic                         grant;

  logic                         out_v_q;
  logic [IdxW-1:0]              out_idx_q;
  logic                         out_last_q;
  logic                         out_safe_q;
  logic                         out_fin_q;

  assign held_in  = {held_c_i, held_b_i, held_a_i};
  assign claim_in = {claim_c_i, claim_b_i, claim_a_i};

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_LOAD) || out_v_q;
  assign accept      = start && !busy;
  assign room        = (loaded_q < CntW'(MaxP));
  assign idx_wrap    = ((CntW'(idx_q) + CntW'(1)) == loaded_q);
  assign eidx_end    = ((CntW'(eidx_q) + CntW'(1)) == loaded_q);
  assign pass_end    = ((CntW'(pass_q) + CntW'(1)) == loaded_q);

  always_comb begin
    for (int r = 0; r < NumRes; r++) begin
      pwr.held[r] = held_in[r];
      pwr.need[r] = {1'b0, claim_in[r]} - {1'b0, held_in[r]};
    end
  end

  for (genvar r = 0; r < NumRes; r++) begin : g_lane
    bsc_lane u_lane (
      .free_i (free_q[r]),
      .held_i (prd_q.held[r]),
      .need_i (prd_q.need[r]),
      .res_o  (lane_res[r])
    );
  end

  always_comb begin
    fits_all = 1'b1;
    for (int r = 0; r < NumRes; r++) begin
      fits_all = fits_all & lane_res[r].fits;
    end
  end

  assign grant = (state_q == S_WALK) && !fin_q[eidx_q] && fits_all;

  always_comb begin
    rwr.order = granted_q + CntW'(1);
    for (int r = 0; r < NumRes; r++) begin
      rwr.free[r] = lane_res[r].free_next;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_LOAD: begin
        if (accept && final_process_i) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        state_d = S_WALK;
        idx_d   = idx_wrap ? '0 : idx_q + IdxW'(1);
      end
      S_WALK: begin
        idx_d = idx_wrap ? '0 : idx_q + IdxW'(1);
        if (eidx_end && pass_end) begin
          state_d = S_EMIT;
          idx_d   = '0;
        end
      end
      S_EMIT: begin
        idx_d = idx_wrap ? '0 : idx_q + IdxW'(1);
        if (idx_wrap) begin
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      idx_q      <= '0;
      eidx_q     <= '0;
      pass_q     <= '0;
      loaded_q   <= '0;
      granted_q  <= '0;
      fin_q      <= '0;
      total_q    <= '0;
      sum_q      <= '0;
      free_q     <= '0;
      out_v_q    <= 1'b0;
      out_idx_q  <= '0;
      out_last_q <= 1'b0;
      out_safe_q <= 1'b0;
      out_fin_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bsc_pkg::CFG_TOTAL_A: total_q[0] <= cfg_data_i;
          bsc_pkg::CFG_TOTAL_B: total_q[1] <= cfg_data_i;
          bsc_pkg::CFG_TOTAL_C: total_q[2] <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (accept && room) begin
        loaded_q <= loaded_q + CntW'(1);
        for (int r = 0; r < NumRes; r++) begin
          sum_q[r] <= sum_q[r] + {{(SumW - ResW){1'b0}}, held_in[r]};
        end
      end

      if (state_q == S_INIT) begin
        eidx_q    <= '0;
        pass_q    <= '0;
        granted_q <= '0;
        fin_q     <= '0;
        for (int r = 0; r < NumRes; r++) begin
          free_q[r] <= {{(FreeW - ResW){1'b0}}, total_q[r]}
                     - {{(FreeW - SumW){1'b0}}, sum_q[r]};
        end
      end

      if (state_q == S_WALK) begin
        eidx_q <= idx_q;
        if (eidx_end) begin
          pass_q <= pass_q + IdxW'(1);
        end
        if (grant) begin
          granted_q     <= granted_q + CntW'(1);
          fin_q[eidx_q] <= 1'b1;
          for (int r = 0; r < NumRes; r++) begin
            free_q[r] <= lane_res[r].free_next;
          end
        end
      end

      out_v_q    <= (state_q == S_EMIT);
      out_idx_q  <= idx_q;
      out_last_q <= (state_q == S_EMIT) && idx_wrap;
      out_safe_q <= (state_q == S_EMIT) && idx_wrap && (granted_q == loaded_q);
      out_fin_q  <= fin_q[idx_q];

      if ((state_q == S_EMIT) && idx_wrap) begin
        loaded_q <= '0;
        sum_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      pmem[loaded_q[IdxW-1:0]] <= pwr;
    end
    prd_q <= pmem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (grant) begin
      rmem[eidx_q] <= rwr;
    end
    rrd_q <= rmem[idx_q];
  end

  assign result_valid_o  = out_v_q;
  assign process_index_o = 4'(out_idx_q);
  assign finish_order_o  = out_fin_q ? 5'(rrd_q.order) : '0;
  assign free_a_after_o  = out_fin_q ? $signed(13'(rrd_q.free[0])) : '0;
  assign free_b_after_o  = out_fin_q ? $signed(13'(rrd_q.free[1])) : '0;
  assign free_c_after_o  = out_fin_q ? $signed(13'(rrd_q.free[2])) : '0;
  assign system_safe_o   = out_safe_q;
  assign last_result_o   = out_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bsc_checker.sv -----
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the safety check block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bankers_safety_check_top_assert.svh"

module bsc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic final_process_i,
  input logic result_valid_o,
  input logic system_safe_o,
  input logic last_result_o
);

  `BSC_ASSERT_NOW(a_result_while_busy, result_valid_o, busy)
  `BSC_ASSERT_NEXT(a_load_stays_idle, start && !busy && !final_process_i, !busy)
  `BSC_ASSERT_NEXT(a_final_starts_check, start && !busy && final_process_i, busy)
  `BSC_ASSERT_NEXT(a_report_ends, result_valid_o && last_result_o, !result_valid_o)
  `BSC_ASSERT_NOW(a_safe_on_last, system_safe_o, last_result_o && result_valid_o)

endmodule

bind bankers_safety_check_top bsc_checker u_bsc_checker (.*);

`default_nettype wire

// ----- sim/bankers_safety_check_top_tb.sv -----
// ----------------------------------------------------------------------------
// bankers_safety_check_top_tb
// Self-checking bench for the Banker's safety check block. A planned list of
// process items and register writes is driven with random gaps. Each
// accepted batch is scored by a local model of the safety walk, and every
// report result is compared against it as it comes out.
// ----------------------------------------------------------------------------
module bankers_safety_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP        = bsc_pkg::MAX_PROCESSES;
  localparam int IDLE_PCT    = 38;
  localparam int SETTLE      = 4;
  localparam int TAIL_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int ITEM_GOAL   = 260;
  localparam logic [bsc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_e;

  typedef struct packed {
    step_kind_e                     kind;
    logic [2:0][7:0]                held;
    logic [2:0][7:0]                claim;
    logic                           fin;
    logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [7:0]                     cfg_data;
  } step_t;

  typedef struct packed {
    logic [3:0]         index;
    logic [4:0]         order;
    logic signed [12:0] free_a;
    logic signed [12:0] free_b;
    logic signed [12:0] free_c;
    logic               safe;
    logic               last;
  } report_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [7:0]                    held_a_i = '0, held_b_i = '0, held_c_i = '0;
  logic [7:0]                    claim_a_i = '0, claim_b_i = '0, claim_c_i = '0;
  logic                          final_process_i = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]                    cfg_data_i = '0;
  logic                          result_valid_o;
  logic [3:0]                    process_index_o;
  logic [4:0]                    finish_order_o;
  logic signed [12:0]            free_a_after_o, free_b_after_o, free_c_after_o;
  logic                          system_safe_o;
  logic                          last_result_o;

  step_t      plan_q [$];
  report_t    report_q [$];
  step_t      cur_step;
  logic [7:0] totals [3];
  logic [7:0] held_tab [MAXP][3];
  int         need_tab [MAXP][3];
  int         loaded;
  int         items_sent;
  int         items_planned;
  int         settle_cnt;
  int         error_count;
  int         quiet_cnt;

  bankers_safety_check_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .held_a_i        (held_a_i),
    .held_b_i        (held_b_i),
    .held_c_i        (held_c_i),
    .claim_a_i       (claim_a_i),
    .claim_b_i       (claim_b_i),
    .claim_c_i       (claim_c_i),
    .final_process_i (final_process_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .process_index_o (process_index_o),
    .finish_order_o  (finish_order_o),
    .free_a_after_o  (free_a_after_o),
    .free_b_after_o  (free_b_after_o),
    .free_c_after_o  (free_c_after_o),
    .system_safe_o   (system_safe_o),
    .last_result_o   (last_result_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void set_total(logic [bsc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
    case (idx)
      bsc_pkg::CFG_TOTAL_A: totals[0] = data;
      bsc_pkg::CFG_TOTAL_B: totals[1] = data;
      bsc_pkg::CFG_TOTAL_C: totals[2] = data;
      default: ;
    endcase
  endfunction

  // store one process; on the final mark, run the walk and queue the report
  function automatic void load_process(step_t s);
    int      avail [3];
    int      freed [MAXP][3];
    int      order [MAXP];
    int      granted;
    bit      fits;
    report_t rep;
    if (loaded < MAXP) begin
      for (int r = 0; r < 3; r++) begin
        held_tab[loaded][r] = s.held[r];
        need_tab[loaded][r] = int'(s.claim[r]) - int'(s.held[r]);
      end
      loaded++;
    end
    if (!s.fin) return;
    for (int r = 0; r < 3; r++) begin
      avail[r] = int'(totals[r]);
      for (int p = 0; p < loaded; p++) avail[r] -= int'(held_tab[p][r]);
    end
    for (int p = 0; p < MAXP; p++) begin
      order[p] = 0;
      for (int r = 0; r < 3; r++) freed[p][r] = 0;
    end
    granted = 0;
    for (int sweep = 0; sweep < loaded; sweep++) begin
      for (int p = 0; p < loaded; p++) begin
        if (order[p] == 0) begin
          fits = 1'b1;
          for (int r = 0; r < 3; r++)
            if (need_tab[p][r] > avail[r]) fits = 1'b0;
          if (fits) begin
            for (int r = 0; r < 3; r++) begin
              avail[r] += int'(held_tab[p][r]);
              freed[p][r] = avail[r];
            end
            granted++;
            order[p] = granted;
          end
        end
      end
    end
    for (int p = 0; p < loaded; p++) begin
      rep.index  = 4'(p);
      rep.order  = 5'(order[p]);
      rep.free_a = (order[p] != 0) ? 13'(freed[p][0]) : '0;
      rep.free_b = (order[p] != 0) ? 13'(freed[p][1]) : '0;
      rep.free_c = (order[p] != 0) ? 13'(freed[p][2]) : '0;
      rep.last   = (p == loaded - 1);
      rep.safe   = rep.last && (granted == loaded);
      report_q.push_back(rep);
    end
    loaded = 0;
  endfunction

  function automatic void add_item(logic [23:0] held, logic [23:0] claim, logic fin);
    step_t s;
    s = '0;
    s.kind  = STEP_ITEM;
    s.held  = held;
    s.claim = claim;
    s.fin   = fin;
    plan_q.push_back(s);
    items_planned++;
  endfunction

  function automatic void add_cfg(logic [bsc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
    step_t s;
    s = '0;
    s.kind      = STEP_CFG;
    s.cfg_index = idx;
    s.cfg_data  = data;
    plan_q.push_back(s);
  endfunction

  function automatic void add_drain();
    step_t s;
    s = '0;
    s.kind = STEP_DRAIN;
    plan_q.push_back(s);
  endfunction

  function automatic logic [7:0] rand_total();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // wide=1: any byte values; otherwise small holdings with claims at or above them
  function automatic void add_batch(int n, bit wide);
    logic [23:0] held, claim;
    int          c;
    for (int i = 0; i < n; i++) begin
      for (int r = 0; r < 3; r++) begin
        if (wide) begin
          held[r*8 +: 8]  = 8'($urandom_range(255));
          claim[r*8 +: 8] = 8'($urandom_range(255));
        end else begin
          held[r*8 +: 8] = 8'($urandom_range(24));
          c = int'(held[r*8 +: 8]) + $urandom_range(40);
          claim[r*8 +: 8] = 8'((c > 255) ? 255 : c);
        end
      end
      add_item(held, claim, i == n - 1);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
      settle_cnt  <= 0;
    end else begin : drive_blk
      logic go_item, go_cfg;
      go_item = start;
      go_cfg  = cfg_valid_i;
      if (start && !busy) begin
        load_process(cur_step);
        go_item = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        set_total(cur_step.cfg_index, cur_step.cfg_data);
        go_cfg = 1'b0;
      end
      if (!go_item && !go_cfg && plan_q.size() != 0) begin
        if (plan_q[0].kind == STEP_ITEM) begin
          if ((items_sent >= 120 && items_sent < 180) || $urandom_range(99) >= IDLE_PCT) begin
            cur_step = plan_q.pop_front();
            held_a_i        <= cur_step.held[0];
            held_b_i        <= cur_step.held[1];
            held_c_i        <= cur_step.held[2];
            claim_a_i       <= cur_step.claim[0];
            claim_b_i       <= cur_step.claim[1];
            claim_c_i       <= cur_step.claim[2];
            final_process_i <= cur_step.fin;
            go_item = 1'b1;
            items_sent++;
          end
        end else if (report_q.size() == 0 && !busy) begin
          // block idle: let it settle before touching the registers
          if (settle_cnt < SETTLE) begin
            settle_cnt <= settle_cnt + 1;
          end else begin
            settle_cnt <= 0;
            cur_step = plan_q.pop_front();
            if (cur_step.kind == STEP_CFG) begin
              cfg_index_i <= cur_step.cfg_index;
              cfg_data_i  <= cur_step.cfg_data;
              go_cfg = 1'b1;
            end
          end
        end else begin
          settle_cnt <= 0;
        end
      end
      start       <= go_item;
      cfg_valid_i <= go_cfg;
    end
  end

  always @(posedge clk_i) begin : check_blk
    report_t seen, want;
    if (rst_ni && result_valid_o) begin
      seen = {process_index_o, finish_order_o, free_a_after_o, free_b_after_o,
              free_c_after_o, system_safe_o, last_result_o};
      if (report_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: idx %0d ord %0d", seen.index, seen.order);
      end else begin
        want = report_q.pop_front();
        if (seen !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch exp: idx %0d ord %0d free %0d/%0d/%0d safe %b last %b",
                     want.index, want.order, want.free_a, want.free_b, want.free_c,
                     want.safe, want.last);
            $display("         act: idx %0d ord %0d free %0d/%0d/%0d safe %b last %b",
                     seen.index, seen.order, seen.free_a, seen.free_b, seen.free_c,
                     seen.safe, seen.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o)
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("bankers_safety_check_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int n;
    totals[0]     = '0;
    totals[1]     = '0;
    totals[2]     = '0;
    loaded        = 0;
    items_sent    = 0;
    items_planned = 0;
    error_count   = 0;
    quiet_cnt     = 0;

    // textbook five-process case, safe with a non-index finish order
    add_cfg(bsc_pkg::CFG_TOTAL_A, 8'd10);
    add_cfg(bsc_pkg::CFG_TOTAL_B, 8'd5);
    add_cfg(bsc_pkg::CFG_TOTAL_C, 8'd7);
    add_cfg(CFG_SPARE, 8'd99);
    add_item({8'd0, 8'd1, 8'd0}, {8'd3, 8'd5, 8'd7}, 1'b0);
    add_item({8'd0, 8'd0, 8'd2}, {8'd2, 8'd2, 8'd3}, 1'b0);
    add_item({8'd2, 8'd0, 8'd3}, {8'd2, 8'd0, 8'd9}, 1'b0);
    add_item({8'd1, 8'd1, 8'd2}, {8'd2, 8'd2, 8'd2}, 1'b0);
    add_item({8'd2, 8'd0, 8'd0}, {8'd3, 8'd3, 8'd4}, 1'b1);
    // single process batch
    add_item('0, '0, 1'b1);
    // nothing available: full claims deadlock, zero claim finishes
    add_cfg(bsc_pkg::CFG_TOTAL_A, 8'd0);
    add_cfg(bsc_pkg::CFG_TOTAL_B, 8'd0);
    add_cfg(bsc_pkg::CFG_TOTAL_C, 8'd0);
    add_item('0, '1, 1'b0);
    add_item('0, '1, 1'b1);
    add_item('0, '0, 1'b1);
    // over-allocated totals, negative need and negative availability
    add_cfg(bsc_pkg::CFG_TOTAL_A, 8'd255);
    add_cfg(bsc_pkg::CFG_TOTAL_B, 8'd255);
    add_cfg(bsc_pkg::CFG_TOTAL_C, 8'd255);
    add_item('1, '0, 1'b0);
    add_item('1, '1, 1'b1);
    // partial deadlock
    add_cfg(bsc_pkg::CFG_TOTAL_B, 8'd0);
    add_cfg(bsc_pkg::CFG_TOTAL_C, 8'd128);
    add_item({8'd50, 8'd0, 8'd100}, {8'd60, 8'd0, 8'd200}, 1'b0);
    add_item('0, '1, 1'b0);
    add_item({8'd10, 8'd0, 8'd20}, {8'd10, 8'd0, 8'd20}, 1'b1);
    add_drain();

    while (items_planned < ITEM_GOAL) begin
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(3) == 0) begin
          add_cfg(bsc_pkg::CFG_TOTAL_A, rand_total());
          add_cfg(bsc_pkg::CFG_TOTAL_B, rand_total());
          add_cfg(bsc_pkg::CFG_TOTAL_C, rand_total());
        end else begin
          case ($urandom_range(2))
            0: add_cfg(bsc_pkg::CFG_TOTAL_A, rand_total());
            1: add_cfg(bsc_pkg::CFG_TOTAL_B, rand_total());
            default: add_cfg(bsc_pkg::CFG_TOTAL_C, rand_total());
          endcase
        end
      end else if ($urandom_range(99) < 10) begin
        add_drain();
      end
      n = $urandom_range(99);
      if (n < 70)
        n = $urandom_range(6, 1);
      else if (n < 93)
        n = $urandom_range(16, 7);
      else
        n = $urandom_range(20, 17);
      add_batch(n, $urandom_range(99) < 25);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (plan_q.size() != 0 || start || cfg_valid_i || report_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0 && report_q.size() == 0)
      $display("bankers_safety_check_top_tb: done, clean");
    else
      $display("bankers_safety_check_top_tb: done, errors");
    $finish;
  end

endmodule
